>>> hdl/fwqe_pkg.sv
// Shared types and codes for the futex wait-queue engine.
`timescale 1ns / 1ps

package fwqe_pkg;

    // Operation kinds
    localparam logic [1:0] KIND_WAIT = 2'd0;
    localparam logic [1:0] KIND_WAKE = 2'd1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_WAITING  = 2'd3;

    // Most tasks released by one wake, and the width of a count up to it
    localparam int          CNT_W    = 6;
    localparam logic [5:0]  MAX_WAKE = 6'd32;

    // Request payload
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] address;
        logic [4:0]  task_id;
        logic [31:0] operand_value;
        logic [31:0] current_value;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [1:0] status;
        logic       woken_valid;
        logic [4:0] woken_task;
        logic [5:0] bucket;
        logic       last;
    } t_rsp;

endpackage

>>> hdl/futex_wait_queue_engine.sv
// Futex wait-queue engine: hashed buckets of LIFO task lists in block memories.
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_ready    i_in_data  (fwqe_pkg::t_req)
//   result    out        o_out_valid / i_out_ready  o_out_data (fwqe_pkg::t_rsp)
//
// A wait or an invalid op: the transfer issues the head-table read, then S_EXEC
// checks, writes back and loads the result register.
// A wake pops its released tasks one at a time; each pop waits in S_LINK on the
// next-link read. After reset the head table is swept clear, with o_in_ready
// low. A result held by i_out_ready low stalls the engine in place.
`timescale 1ns / 1ps

module futex_wait_queue_engine #(
    parameter int BUCKET_BITS = 6,
    parameter int MAX_TASKS   = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fwqe_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fwqe_pkg::t_rsp o_out_data
);

    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
    localparam int TW          = $clog2(MAX_TASKS);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_LINK  = 4'b1000
    } t_state;

    // Table entry: valid flag over a task index
    typedef logic [TW:0] t_entry;

    t_state                  r_state,    n_state;
    fwqe_pkg::t_req          r_in,       n_in;
    logic [TW-1:0]           r_cur,      n_cur;
    logic [fwqe_pkg::CNT_W-1:0] r_cnt,   n_cnt;
    logic [fwqe_pkg::CNT_W-1:0] r_limit, n_limit;
    logic [BUCKET_BITS-1:0]  r_clr,      n_clr;
    logic [MAX_TASKS-1:0]    r_waiting,  n_waiting;
    logic                    r_out_valid, n_out_valid;
    fwqe_pkg::t_rsp          r_out,      n_out;

    t_entry                  r_head_mem [NUM_BUCKETS];
    t_entry                  r_link_mem [MAX_TASKS];
    t_entry                  r_head_rd;
    t_entry                  r_link_rd;

    logic                    head_we, head_re, link_we, link_re;
    logic [BUCKET_BITS-1:0]  head_wa, head_ra;
    t_entry                  head_wd;
    logic [TW-1:0]           link_wa, link_ra;
    t_entry                  link_wd;

    logic                    out_free;
    logic [BUCKET_BITS-1:0]  bkt;
    logic [5:0]              bkt_out;
    logic [TW-1:0]           tidx;
    logic [fwqe_pkg::CNT_W-1:0] req_limit;
    logic                    more;

    assign out_free  = !r_out_valid || i_out_ready;
    assign bkt       = r_in.address[BUCKET_BITS+1:2];
    assign bkt_out   = 6'(bkt);
    assign tidx      = TW'(r_in.task_id);
    assign req_limit = (r_in.operand_value >= 32'(fwqe_pkg::MAX_WAKE)) ?
                       fwqe_pkg::MAX_WAKE : r_in.operand_value[fwqe_pkg::CNT_W-1:0];
    assign more      = (r_cnt < r_limit) && r_link_rd[TW];

    // Control and table updates
    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_limit     = r_limit;
        n_clr       = r_clr;
        n_waiting   = r_waiting;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        head_we     = 1'b0;
        head_wa     = bkt;
        head_wd     = r_link_rd;
        head_re     = 1'b0;
        head_ra     = i_in_data.address[BUCKET_BITS+1:2];
        link_we     = 1'b0;
        link_wa     = tidx;
        link_wd     = r_head_rd;
        link_re     = 1'b0;
        link_ra     = r_head_rd[TW-1:0];

        case (r_state)
            S_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                head_wd = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == {BUCKET_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    head_re = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out.status      = fwqe_pkg::ST_OK;
                    n_out.woken_valid = 1'b0;
                    n_out.woken_task  = '0;
                    n_out.bucket      = bkt_out;
                    n_out.last        = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                    case (r_in.kind)
                        fwqe_pkg::KIND_WAIT: begin
                            if (int'(r_in.task_id) >= MAX_TASKS) begin
                                n_out.status = fwqe_pkg::ST_INVALID;
                            end else if (r_waiting[tidx]) begin
                                n_out.status = fwqe_pkg::ST_WAITING;
                            end else if (r_in.current_value != r_in.operand_value) begin
                                n_out.status = fwqe_pkg::ST_MISMATCH;
                            end else begin
                                // push: new task links to the old head
                                link_we         = 1'b1;
                                head_we         = 1'b1;
                                head_wd         = {1'b1, tidx};
                                n_waiting[tidx] = 1'b1;
                            end
                        end
                        fwqe_pkg::KIND_WAKE: begin
                            if (req_limit != '0 && r_head_rd[TW]) begin
                                // first pop; its result goes out once the link is known
                                n_out_valid = r_out_valid && !i_out_ready;
                                n_out       = r_out;
                                link_re     = 1'b1;
                                n_waiting[r_head_rd[TW-1:0]] = 1'b0;
                                n_cur       = r_head_rd[TW-1:0];
                                n_cnt       = fwqe_pkg::CNT_W'(1);
                                n_limit     = req_limit;
                                n_state     = S_LINK;
                            end
                        end
                        default: begin
                            n_out.status = fwqe_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_LINK: begin
                if (out_free) begin
                    // emit popped task, head takes its successor
                    n_out.status      = fwqe_pkg::ST_OK;
                    n_out.woken_valid = 1'b1;
                    n_out.woken_task  = 5'(r_cur);
                    n_out.bucket      = bkt_out;
                    n_out.last        = !more;
                    n_out_valid       = 1'b1;
                    head_we           = 1'b1;
                    if (more) begin
                        link_re   = 1'b1;
                        link_ra   = r_link_rd[TW-1:0];
                        n_waiting[r_link_rd[TW-1:0]] = 1'b0;
                        n_cur     = r_link_rd[TW-1:0];
                        n_cnt     = r_cnt + 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_waiting   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_waiting   <= n_waiting;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_cur   <= n_cur;
        r_cnt   <= n_cnt;
        r_limit <= n_limit;
        r_out   <= n_out;
    end

    // Head table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[head_wa] <= head_wd;
        end
        if (head_re) begin
            r_head_rd <= r_head_mem[head_ra];
        end
    end

    // Next-link table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_wa] <= link_wd;
        end
        if (link_re) begin
            r_link_rd <= r_link_mem[link_ra];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
